### hdl/grid_ray_traversal_top_macros.svh
// assertion macros for the grid ray traversal block
`ifndef GRID_RAY_TRAVERSAL_TOP_MACROS_SVH
`define GRID_RAY_TRAVERSAL_TOP_MACROS_SVH

// same-cycle implication
`define GRT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GRT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/grt_pkg.sv
package grt_pkg;

  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int MAX_DIM   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int CNT_W     = $clog2(MAX_DIM + 1);
  localparam int IDX_W     = CNT_W + 1;
  localparam int COL_AW    = $clog2(MAX_COLS);
  localparam int ROW_AW    = $clog2(MAX_ROWS);
  localparam int STEP_W    = $clog2(MAX_COLS + MAX_ROWS + 5);
  localparam int DIV_STEPS = 64;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam int IN_W  = 120;
  localparam int OUT_W = 32;

  typedef logic signed [63:0] sword_t;
  typedef logic [MAX_COLS-1:0] row_t;

  localparam sword_t T_INF    = 64'sh4000_0000_0000_0000;
  localparam sword_t DIST_MAX = 64'sh0000_0000_7FFF_FFFF;

  localparam logic [2:0] CFG_GX0  = 3'd0;
  localparam logic [2:0] CFG_GY0  = 3'd1;
  localparam logic [2:0] CFG_CS   = 3'd2;
  localparam logic [2:0] CFG_COLS = 3'd3;
  localparam logic [2:0] CFG_ROWS = 3'd4;

  typedef struct packed {
    logic                start;
    logic                floor_mode;
    sword_t              dividend;
    logic signed [31:0]  divisor;
  } div_req_t;

endpackage

### hdl/grt_row_ram.sv
module grt_row_ram
  import grt_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ROW_AW-1:0] rd_addr,
  output row_t              rd_data,
  input  logic              wr_en,
  input  logic [ROW_AW-1:0] wr_addr,
  input  row_t              wr_data
);

  row_t mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/grt_div.sv
module grt_div
  import grt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output logic     done,
  output sword_t   quot
);

  logic [DCNT_W-1:0] cnt;
  logic [63:0]       q;
  logic [31:0]       rem;
  logic [31:0]       den;
  logic              neg;
  logic              flr;
  logic [32:0]       rsh;
  logic [32:0]       dif;
  logic              take;
  sword_t            qs;

  assign rsh  = {rem, q[63]};
  assign dif  = rsh - {1'b0, den};
  assign take = !dif[32];

  // sign fixup, floor mode pulls negative inexact quotients down by one
  always_comb begin
    qs = neg ? -sword_t'(q) : sword_t'(q);
    if (flr && neg && (rem != 32'd0)) begin
      qs = qs - 64'sd1;
    end
  end
  assign quot = qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= DCNT_W'(DIV_STEPS);
        q   <= req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
        rem <= '0;
        den <= req.divisor[31] ? 32'(-req.divisor) : 32'(req.divisor);
        neg <= req.dividend[63] ^ req.divisor[31];
        flr <= req.floor_mode;
      end else if (cnt != '0) begin
        cnt <= cnt - DCNT_W'(1);
        q   <= {q[62:0], take};
        rem <= take ? dif[31:0] : rsh[31:0];
        if (cnt == DCNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/grid_ray_traversal_top.sv
// write word: a row read of the occupancy ram and its write back, no result
// ray word: 2 to 13 divisions on the shared radix-2 divider at setup, then the walk from
// cell to cell (one row read of the occupancy ram per step)
// one word is in work at a time; the result register lets the next word in while it waits
// reset (synchronous, active high) clears the occupancy ram one row a cycle, all MAX_ROWS rows
module grid_ray_traversal_top
  import grt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // ray_origin_x[31:0] ray_origin_y[63:32] ray_dir_x[79:64] ray_dir_y[95:80]
  // cell_col[103:96] cell_row[111:104] cell_occupied[112] zero[119:113]
  input  logic [IN_W-1:0]  s_axis_tdata,
  // mode[0]
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // hit_distance[30:0] zero[31]
  output logic [OUT_W-1:0] m_axis_tdata,
  // hit[0]
  output logic             m_axis_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_WRD   = 5'd2;
  localparam logic [4:0] ST_WWB   = 5'd3;
  localparam logic [4:0] ST_DCX   = 5'd4;
  localparam logic [4:0] ST_DCY   = 5'd5;
  localparam logic [4:0] ST_CHK   = 5'd6;
  localparam logic [4:0] ST_SX1   = 5'd7;
  localparam logic [4:0] ST_SX2   = 5'd8;
  localparam logic [4:0] ST_SY1   = 5'd9;
  localparam logic [4:0] ST_SY2   = 5'd10;
  localparam logic [4:0] ST_SLAB  = 5'd11;
  localparam logic [4:0] ST_EMUL  = 5'd12;
  localparam logic [4:0] ST_EDIV  = 5'd13;
  localparam logic [4:0] ST_ECX   = 5'd14;
  localparam logic [4:0] ST_ECY   = 5'd15;
  localparam logic [4:0] ST_RD0   = 5'd16;
  localparam logic [4:0] ST_RD0W  = 5'd17;
  localparam logic [4:0] ST_TDX   = 5'd18;
  localparam logic [4:0] ST_TDY   = 5'd19;
  localparam logic [4:0] ST_TMX   = 5'd20;
  localparam logic [4:0] ST_TMY   = 5'd21;
  localparam logic [4:0] ST_WSTEP = 5'd22;
  localparam logic [4:0] ST_WCK   = 5'd23;
  localparam logic [4:0] ST_OUT   = 5'd24;

  localparam logic signed [IDX_W-1:0] IDX_ONE = IDX_W'(1);

  // configuration
  logic signed [31:0] gx0;
  logic signed [31:0] gy0;
  logic [30:0]        csize;
  logic [8:0]         gcols;
  logic [8:0]         grows;

  logic [30:0]        cs;
  logic [CNT_W-1:0]   cols;
  logic [CNT_W-1:0]   rows;
  sword_t             cs64;
  sword_t             gx0e;
  sword_t             gy0e;
  sword_t             cols64;
  sword_t             rows64;
  logic signed [IDX_W-1:0] cols_s;
  logic signed [IDX_W-1:0] rows_s;
  logic [CNT_W+30:0]  span_x;
  logic [CNT_W+30:0]  span_y;
  sword_t             gx1;
  sword_t             gy1;
  logic [STEP_W-1:0]  step_lim;

  // sequencer
  logic [4:0]         state;
  logic               div_wait;
  logic [ROW_AW-1:0]  clr_row;

  sword_t             oxr;
  sword_t             oyr;
  logic signed [15:0] dxr;
  logic signed [15:0] dyr;
  logic [COL_AW-1:0]  wcol;
  logic [ROW_AW-1:0]  wrow;
  logic               wocc;
  logic               wok;
  logic               xz;
  logic               yz;

  sword_t             qx;
  sword_t             qy;
  sword_t             t1x;
  sword_t             t2x;
  sword_t             t1y;
  sword_t             t2y;
  sword_t             base;
  logic               ent_axis;
  sword_t             ent_edge;
  sword_t             prod;
  sword_t             px;
  sword_t             py;
  logic signed [IDX_W-1:0] cx;
  logic signed [IDX_W-1:0] cy;
  sword_t             ex;
  sword_t             ey;
  sword_t             tdx;
  sword_t             tdy;
  sword_t             tmx;
  sword_t             tmy;
  sword_t             tcur;
  logic               step_x;
  logic [STEP_W-1:0]  scnt;
  logic               found;
  sword_t             res_t;
  logic               m_hit;
  logic [30:0]        m_dist;

  // divider and ram
  div_req_t           dreq;
  logic               div_done;
  sword_t             quot;
  logic               ram_rd_en;
  logic [ROW_AW-1:0]  ram_rd_addr;
  row_t               ram_rdata;
  logic               ram_wr_en;
  logic [ROW_AW-1:0]  ram_wr_addr;
  row_t               ram_wdata;

  // combinational helpers
  logic               slab_fail;
  logic               slab_ax;
  sword_t             slab_tn;
  sword_t             slab_edge;
  sword_t             sa;
  sword_t             sb;
  sword_t             se;
  sword_t             stf;
  logic               sok;
  logic               sset;
  logic signed [43:0] ediff;
  logic signed [15:0] emul_d;
  logic signed [59:0] eprod;
  logic [IDX_W+30:0]  ex_span;
  logic [IDX_W+30:0]  ey_span;
  logic signed [IDX_W-1:0] ncx;
  logic signed [IDX_W-1:0] ncy;
  logic               take_x;
  logic               cell_bit;
  logic signed [IDX_W-1:0] clamp_q;
  sword_t             ab_dx;
  sword_t             ab_dy;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {1'b0, m_dist};
  assign m_axis_tuser  = m_hit;

  // effective grid geometry
  always_comb begin
    cs = (csize == 31'd0) ? 31'd1 : csize;
    if (gcols == 9'd0) begin
      cols = CNT_W'(1);
    end else if (32'(gcols) > MAX_COLS) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = CNT_W'(gcols);
    end
    if (grows == 9'd0) begin
      rows = CNT_W'(1);
    end else if (32'(grows) > MAX_ROWS) begin
      rows = CNT_W'(MAX_ROWS);
    end else begin
      rows = CNT_W'(grows);
    end
  end

  assign cs64     = sword_t'({33'd0, cs});
  assign gx0e     = sword_t'(gx0);
  assign gy0e     = sword_t'(gy0);
  assign cols64   = sword_t'({{(64-CNT_W){1'b0}}, cols});
  assign rows64   = sword_t'({{(64-CNT_W){1'b0}}, rows});
  assign cols_s   = {1'b0, cols};
  assign rows_s   = {1'b0, rows};
  assign span_x   = (CNT_W+31)'(cols) * (CNT_W+31)'(cs);
  assign span_y   = (CNT_W+31)'(rows) * (CNT_W+31)'(cs);
  assign step_lim = STEP_W'(cols) + STEP_W'(rows) + STEP_W'(4);

  always_ff @(posedge clk) begin
    gx1 <= gx0e + sword_t'({{(33-CNT_W){1'b0}}, span_x});
    gy1 <= gy0e + sword_t'({{(33-CNT_W){1'b0}}, span_y});
  end

  // slab clip of a ray that starts off the grid
  always_comb begin
    sok       = 1'b1;
    sset      = 1'b0;
    slab_ax   = 1'b0;
    slab_tn   = -T_INF;
    stf       = T_INF;
    slab_edge = '0;
    sa        = '0;
    sb        = '0;
    se        = '0;
    if (xz) begin
      if ((oxr < gx0e) || (oxr > gx1)) sok = 1'b0;
    end else begin
      if (t1x > t2x) begin
        sa = t2x; sb = t1x; se = gx1;
      end else begin
        sa = t1x; sb = t2x; se = gx0e;
      end
      if (sa > slab_tn) begin
        slab_tn = sa; sset = 1'b1; slab_ax = 1'b0; slab_edge = se;
      end
      if (sb < stf) stf = sb;
      if (slab_tn > stf) sok = 1'b0;
    end
    if (yz) begin
      if ((oyr < gy0e) || (oyr > gy1)) sok = 1'b0;
    end else begin
      if (t1y > t2y) begin
        sa = t2y; sb = t1y; se = gy1;
      end else begin
        sa = t1y; sb = t2y; se = gy0e;
      end
      if (sa > slab_tn) begin
        slab_tn = sa; sset = 1'b1; slab_ax = 1'b1; slab_edge = se;
      end
      if (sb < stf) stf = sb;
      if (slab_tn > stf) sok = 1'b0;
    end
    slab_fail = !sok || (stf < 64'sd0) || (slab_tn < 64'sd0) || !sset;
  end

  assign ediff   = ent_axis ? 44'(ent_edge - oyr) : 44'(ent_edge - oxr);
  assign emul_d  = ent_axis ? dxr : dyr;
  assign eprod   = emul_d * ediff;
  assign ex_span = (IDX_W+31)'($unsigned(cx) + ((dxr > 16'sd0) ? IDX_W'(1) : IDX_W'(0)))
                   * (IDX_W+31)'(cs);
  assign ey_span = (IDX_W+31)'($unsigned(cy) + ((dyr > 16'sd0) ? IDX_W'(1) : IDX_W'(0)))
                   * (IDX_W+31)'(cs);
  assign ncx     = (dxr > 16'sd0) ? cx + IDX_ONE : cx - IDX_ONE;
  assign ncy     = (dyr > 16'sd0) ? cy + IDX_ONE : cy - IDX_ONE;
  assign take_x  = (tmx < tmy);
  assign cell_bit = ram_rdata[cx[COL_AW-1:0]];
  assign ab_dx   = (dxr < 16'sd0) ? -sword_t'(dxr) : sword_t'(dxr);
  assign ab_dy   = (dyr < 16'sd0) ? -sword_t'(dyr) : sword_t'(dyr);

  // entry cell index clamped into the grid
  always_comb begin
    if (quot < 64'sd0) begin
      clamp_q = '0;
    end else if (state == ST_ECX) begin
      clamp_q = (quot >= cols64) ? cols_s - IDX_ONE : quot[IDX_W-1:0];
    end else begin
      clamp_q = (quot >= rows64) ? rows_s - IDX_ONE : quot[IDX_W-1:0];
    end
  end

  // divider operand select
  always_comb begin
    dreq.start      = 1'b0;
    dreq.floor_mode = 1'b0;
    dreq.dividend   = '0;
    dreq.divisor    = 32'(dxr);
    case (state)
      ST_DCX: begin
        dreq.start = !div_wait; dreq.floor_mode = 1'b1;
        dreq.dividend = oxr - gx0e; dreq.divisor = {1'b0, cs};
      end
      ST_DCY: begin
        dreq.start = !div_wait; dreq.floor_mode = 1'b1;
        dreq.dividend = oyr - gy0e; dreq.divisor = {1'b0, cs};
      end
      ST_SX1: begin
        dreq.start = !div_wait && !xz;
        dreq.dividend = (gx0e - oxr) <<< 14; dreq.divisor = 32'(dxr);
      end
      ST_SX2: begin
        dreq.start = !div_wait;
        dreq.dividend = (gx1 - oxr) <<< 14; dreq.divisor = 32'(dxr);
      end
      ST_SY1: begin
        dreq.start = !div_wait && !yz;
        dreq.dividend = (gy0e - oyr) <<< 14; dreq.divisor = 32'(dyr);
      end
      ST_SY2: begin
        dreq.start = !div_wait;
        dreq.dividend = (gy1 - oyr) <<< 14; dreq.divisor = 32'(dyr);
      end
      ST_EDIV: begin
        dreq.start = !div_wait; dreq.floor_mode = 1'b1;
        dreq.dividend = prod; dreq.divisor = ent_axis ? 32'(dyr) : 32'(dxr);
      end
      ST_ECX: begin
        dreq.start = !div_wait; dreq.floor_mode = 1'b1;
        dreq.dividend = px - gx0e; dreq.divisor = {1'b0, cs};
      end
      ST_ECY: begin
        dreq.start = !div_wait; dreq.floor_mode = 1'b1;
        dreq.dividend = py - gy0e; dreq.divisor = {1'b0, cs};
      end
      ST_TDX: begin
        dreq.start = !div_wait && !xz;
        dreq.dividend = cs64 <<< 14; dreq.divisor = 32'(ab_dx);
      end
      ST_TDY: begin
        dreq.start = !div_wait && !yz;
        dreq.dividend = cs64 <<< 14; dreq.divisor = 32'(ab_dy);
      end
      ST_TMX: begin
        dreq.start = !div_wait && !xz;
        dreq.dividend = (ex - px) <<< 14; dreq.divisor = 32'(dxr);
      end
      ST_TMY: begin
        dreq.start = !div_wait && !yz;
        dreq.dividend = (ey - py) <<< 14; dreq.divisor = 32'(dyr);
      end
      default: ;
    endcase
  end

  // ram port select
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = cy[ROW_AW-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = wrow;
    ram_wdata   = ram_rdata;
    ram_wdata[wcol] = wocc;
    case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_row;
        ram_wdata   = '0;
      end
      ST_WRD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = wrow;
      end
      ST_WWB:   ram_wr_en = wok;
      ST_RD0:   ram_rd_en = 1'b1;
      ST_WSTEP: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = take_x ? cy[ROW_AW-1:0] : ncy[ROW_AW-1:0];
      end
      default: ;
    endcase
  end

  grt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quot (quot)
  );

  grt_row_ram u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      div_wait      <= 1'b0;
      clr_row       <= '0;
      m_axis_tvalid <= 1'b0;
      gx0           <= '0;
      gy0           <= '0;
      csize         <= 31'd65536;
      gcols         <= 9'd256;
      grows         <= 9'd256;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_GX0:  gx0   <= cfg_data;
          CFG_GY0:  gy0   <= cfg_data;
          CFG_CS:   csize <= cfg_data[30:0];
          CFG_COLS: gcols <= cfg_data[8:0];
          CFG_ROWS: grows <= cfg_data[8:0];
          default: ;
        endcase
      end
      // in ST_OUT the result register reloads on its own
      if (m_axis_tvalid && m_axis_tready && (state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + ROW_AW'(1);
          if (clr_row == ROW_AW'(MAX_ROWS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            oxr  <= sword_t'($signed(s_axis_tdata[31:0]));
            oyr  <= sword_t'($signed(s_axis_tdata[63:32]));
            dxr  <= s_axis_tdata[79:64];
            dyr  <= s_axis_tdata[95:80];
            xz   <= (s_axis_tdata[79:64] == 16'd0);
            yz   <= (s_axis_tdata[95:80] == 16'd0);
            wcol <= COL_AW'(s_axis_tdata[103:96]);
            wrow <= ROW_AW'(s_axis_tdata[111:104]);
            wocc <= s_axis_tdata[112];
            wok  <= (32'(s_axis_tdata[103:96]) < MAX_COLS) &&
                    (32'(s_axis_tdata[111:104]) < MAX_ROWS);
            state <= s_axis_tuser ? ST_WRD : ST_DCX;
          end
        end
        ST_WRD: state <= ST_WWB;
        ST_WWB: state <= ST_IDLE;
        ST_DCX: begin
          if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            qx <= quot; div_wait <= 1'b0; state <= ST_DCY;
          end
        end
        ST_DCY: begin
          if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            qy <= quot; div_wait <= 1'b0; state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if ((qx < 64'sd0) || (qx >= cols64) || (qy < 64'sd0) || (qy >= rows64)) begin
            state <= ST_SX1;
          end else begin
            px    <= oxr;
            py    <= oyr;
            base  <= '0;
            cx    <= qx[IDX_W-1:0];
            cy    <= qy[IDX_W-1:0];
            state <= ST_RD0;
          end
        end
        ST_SX1: begin
          if (xz) state <= ST_SY1;
          else if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            t1x <= quot; div_wait <= 1'b0; state <= ST_SX2;
          end
        end
        ST_SX2: begin
          if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            t2x <= quot; div_wait <= 1'b0; state <= ST_SY1;
          end
        end
        ST_SY1: begin
          if (yz) state <= ST_SLAB;
          else if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            t1y <= quot; div_wait <= 1'b0; state <= ST_SY2;
          end
        end
        ST_SY2: begin
          if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            t2y <= quot; div_wait <= 1'b0; state <= ST_SLAB;
          end
        end
        ST_SLAB: begin
          base     <= slab_tn;
          ent_axis <= slab_ax;
          ent_edge <= slab_edge;
          if (slab_fail) begin
            found <= 1'b0;
            state <= ST_OUT;
          end else begin
            state <= ST_EMUL;
          end
        end
        ST_EMUL: begin
          prod <= sword_t'(eprod);
          if (ent_axis) py <= ent_edge;
          else px <= ent_edge;
          state <= ST_EDIV;
        end
        ST_EDIV: begin
          if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            if (ent_axis) px <= oxr + quot;
            else py <= oyr + quot;
            div_wait <= 1'b0;
            state    <= ST_ECX;
          end
        end
        ST_ECX: begin
          if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            cx <= clamp_q; div_wait <= 1'b0; state <= ST_ECY;
          end
        end
        ST_ECY: begin
          if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            cy <= clamp_q; div_wait <= 1'b0; state <= ST_RD0;
          end
        end
        ST_RD0: state <= ST_RD0W;
        ST_RD0W: begin
          ex <= gx0e + sword_t'({{(33-IDX_W){1'b0}}, ex_span});
          ey <= gy0e + sword_t'({{(33-IDX_W){1'b0}}, ey_span});
          if (cell_bit) begin
            found <= 1'b1;
            res_t <= base;
            state <= ST_OUT;
          end else if (xz && yz) begin
            found <= 1'b0;
            state <= ST_OUT;
          end else begin
            state <= ST_TDX;
          end
        end
        ST_TDX: begin
          if (xz) begin
            tdx <= T_INF; state <= ST_TDY;
          end else if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            tdx <= quot; div_wait <= 1'b0; state <= ST_TDY;
          end
        end
        ST_TDY: begin
          if (yz) begin
            tdy <= T_INF; state <= ST_TMX;
          end else if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            tdy <= quot; div_wait <= 1'b0; state <= ST_TMX;
          end
        end
        ST_TMX: begin
          if (xz) begin
            tmx <= T_INF; state <= ST_TMY;
          end else if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            tmx <= quot; div_wait <= 1'b0; state <= ST_TMY;
          end
        end
        ST_TMY: begin
          scnt <= '0;
          if (yz) begin
            tmy <= T_INF; state <= ST_WSTEP;
          end else if (!div_wait) div_wait <= 1'b1;
          else if (div_done) begin
            tmy <= quot; div_wait <= 1'b0; state <= ST_WSTEP;
          end
        end
        ST_WSTEP: begin
          // ties step in y
          step_x <= take_x;
          if (take_x) begin
            if ((ncx < 0) || (ncx >= cols_s)) begin
              found <= 1'b0;
              state <= ST_OUT;
            end else begin
              cx    <= ncx;
              tcur  <= tmx;
              state <= ST_WCK;
            end
          end else begin
            if ((ncy < 0) || (ncy >= rows_s)) begin
              found <= 1'b0;
              state <= ST_OUT;
            end else begin
              cy    <= ncy;
              tcur  <= tmy;
              state <= ST_WCK;
            end
          end
        end
        ST_WCK: begin
          if (cell_bit) begin
            found <= 1'b1;
            res_t <= base + tcur;
            state <= ST_OUT;
          end else begin
            if (step_x) tmx <= tmx + tdx;
            else tmy <= tmy + tdy;
            if (scnt == step_lim - STEP_W'(1)) begin
              found <= 1'b0;
              state <= ST_OUT;
            end else begin
              scnt  <= scnt + STEP_W'(1);
              state <= ST_WSTEP;
            end
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            // a hit at parameter -1 reads as a miss
            m_hit <= found && (res_t != -64'sd1);
            if (!found || (res_t < 64'sd0)) m_dist <= '0;
            else if (res_t > DIST_MAX) m_dist <= 31'h7FFF_FFFF;
            else m_dist <= res_t[30:0];
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/grt_checker.sv
`include "grid_ray_traversal_top_macros.svh"

module grt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tuser,
  input logic [31:0] m_axis_tdata
);

  // one word in work at a time
  `GRT_ASSERT_NXT(a_one_word, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // a cell write gives no result word
  `GRT_ASSERT_NXT(a_write_silent, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid, !m_axis_tvalid, "result after cell write")

  // a miss carries zero distance
  `GRT_ASSERT_IMP(a_miss_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0, "miss with distance")

  // result held while stalled
  `GRT_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule

bind grid_ray_traversal_top grt_checker u_grt_checker (.*);

### tb/sv/grid_ray_traversal_top_tb.sv
module grid_ray_traversal_top_tb;
  import grt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit MODE_RAY   = 1'b0;
  localparam bit MODE_WRITE = 1'b1;
  localparam longint NO_HIT = -1;

  typedef struct {
    bit                 mode;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [7:0]         col;
    logic [7:0]         row;
    bit                 occ;
  } ray_word_t;

  typedef struct {
    bit        hit;
    bit [30:0] distance;
  } hit_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  grid_ray_traversal_top DUT (.*);

  always #2 clk = ~clk;

  ray_word_t pending_words[$];
  hit_word_t expected_hits[$];
  ray_word_t cur_word;
  bit        occ_map [0:MAX_ROWS*MAX_COLS-1];
  longint    gx0 = 0, gy0 = 0, cs_reg = 65536, cols_reg = 256, rows_reg = 256;
  int        errors = 0;
  bit        idle_on = 1'b1;
  int        send_gap = 0, recv_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (!idle_on || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // ray parameter of the first occupied cell, NO_HIT if none
  function automatic longint trace_ray(longint ox, longint oy, longint dx, longint dy);
    longint cs, cols, rows, gx1, gy1, cx, cy, px, py, base;
    longint tdx, tdy, tmx, tmy, sx, sy, tn, tf, edge_v, t1, t2, e1, steps;
    longint o[2], d[2], lo[2], hi[2];
    int axis;
    bit ok;
    cs = cs_reg != 0 ? cs_reg : 1;
    cols = clamp64(cols_reg, 1, MAX_COLS);
    rows = clamp64(rows_reg, 1, MAX_ROWS);
    gx1 = gx0 + cols * cs;
    gy1 = gy0 + rows * cs;
    cx = floor_div(ox - gx0, cs);
    cy = floor_div(oy - gy0, cs);
    px = ox; py = oy; base = 0; sx = 0; sy = 0;
    if (cx < 0 || cx >= cols || cy < 0 || cy >= rows) begin
      tn = -T_INF; tf = T_INF; edge_v = 0; axis = -1; ok = 1'b1;
      o[0] = ox; o[1] = oy; d[0] = dx; d[1] = dy;
      lo[0] = gx0; lo[1] = gy0; hi[0] = gx1; hi[1] = gy1;
      for (int a = 0; a < 2; a++) begin
        if (d[a] == 0) begin
          if (o[a] < lo[a] || o[a] > hi[a]) ok = 1'b0;
        end else begin
          t1 = (lo[a] - o[a]) * 16384 / d[a];
          t2 = (hi[a] - o[a]) * 16384 / d[a];
          e1 = lo[a];
          if (t1 > t2) begin
            longint sw;
            sw = t1; t1 = t2; t2 = sw; e1 = hi[a];
          end
          if (t1 > tn) begin
            tn = t1; axis = a; edge_v = e1;
          end
          if (t2 < tf) tf = t2;
          if (tn > tf) ok = 1'b0;
        end
      end
      if (!ok || tf < 0 || tn < 0 || axis < 0) return NO_HIT;
      base = tn;
      if (axis == 0) begin
        px = edge_v;
        py = oy + floor_div(dx < 0 ? -(dy * (edge_v - ox)) : dy * (edge_v - ox),
                            dx < 0 ? -dx : dx);
      end else begin
        py = edge_v;
        px = ox + floor_div(dy < 0 ? -(dx * (edge_v - oy)) : dx * (edge_v - oy),
                            dy < 0 ? -dy : dy);
      end
      cx = clamp64(floor_div(px - gx0, cs), 0, cols - 1);
      cy = clamp64(floor_div(py - gy0, cs), 0, rows - 1);
    end
    if (occ_map[cy * MAX_COLS + cx]) return base;
    if (dx == 0 && dy == 0) return NO_HIT;
    tdx = dx != 0 ? cs * 16384 / (dx < 0 ? -dx : dx) : T_INF;
    tdy = dy != 0 ? cs * 16384 / (dy < 0 ? -dy : dy) : T_INF;
    tmx = T_INF; tmy = T_INF;
    if (dx > 0) begin
      sx = 1; tmx = ((gx0 + (cx + 1) * cs) - px) * 16384 / dx;
    end else if (dx < 0) begin
      sx = -1; tmx = ((gx0 + cx * cs) - px) * 16384 / dx;
    end
    if (dy > 0) begin
      sy = 1; tmy = ((gy0 + (cy + 1) * cs) - py) * 16384 / dy;
    end else if (dy < 0) begin
      sy = -1; tmy = ((gy0 + cy * cs) - py) * 16384 / dy;
    end
    steps = cols + rows + 4;
    for (longint s = 0; s < steps; s++) begin
      // ties step in y
      if (tmx < tmy) begin
        cx += sx;
        if (cx < 0 || cx >= cols) return NO_HIT;
        if (occ_map[cy * MAX_COLS + cx]) return base + tmx;
        tmx += tdx;
      end else begin
        cy += sy;
        if (cy < 0 || cy >= rows) return NO_HIT;
        if (occ_map[cy * MAX_COLS + cx]) return base + tmy;
        tmy += tdy;
      end
    end
    return NO_HIT;
  endfunction

  task automatic queue_word(input ray_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic apply_word(input ray_word_t w);
    longint t;
    hit_word_t h;
    if (w.mode == MODE_WRITE) begin
      occ_map[int'(w.row) * MAX_COLS + int'(w.col)] = w.occ;
    end else begin
      t = trace_ray(longint'(w.ox), longint'(w.oy), longint'(w.dx), longint'(w.dy));
      if (t < 0 && t != NO_HIT) t = 0;
      if (t == NO_HIT) begin
        h.hit = 1'b0; h.distance = '0;
      end else begin
        h.hit = 1'b1; h.distance = t > DIST_MAX ? 31'h7FFF_FFFF : t[30:0];
      end
      expected_hits.insert(expected_hits.size(), h);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      s_axis_tvalid <= 1'b1;
    end else begin
      if (s_axis_tvalid) apply_word(cur_word);
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        nv = 1'b1;
        s_axis_tdata <= {7'b0, cur_word.occ, cur_word.row, cur_word.col, cur_word.dy,
                         cur_word.dx, cur_word.oy, cur_word.ox};
        s_axis_tuser <= cur_word.mode;
        send_gap = pick_gap();
      end
      s_axis_tvalid <= nv;
    end
  end

  // result monitor
  always @(posedge clk) begin
    hit_word_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hits.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word hit=%0b dist=%0d",
                                     m_axis_tuser, m_axis_tdata[30:0]);
        end else begin
          e = expected_hits.pop_front();
          if (m_axis_tuser !== e.hit || m_axis_tdata !== {1'b0, e.distance}) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected hit=%0b dist=%0d, got hit=%0b data=%h",
                       e.hit, e.distance, m_axis_tuser, m_axis_tdata);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) recv_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GX0:  gx0 = longint'(signed'(val));
      CFG_GY0:  gy0 = longint'(signed'(val));
      CFG_CS:   cs_reg = longint'(val[30:0]);
      CFG_COLS: cols_reg = longint'(val[8:0]);
      CFG_ROWS: rows_reg = longint'(val[8:0]);
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [31:0] ox0, oy0, csz, input logic [8:0] nc, nr);
    write_reg(CFG_GX0, ox0);
    write_reg(CFG_GY0, oy0);
    write_reg(CFG_CS, csz);
    write_reg(CFG_COLS, {23'b0, nc});
    write_reg(CFG_ROWS, {23'b0, nr});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || expected_hits.size() != 0);
    // writes leave no result behind them
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord(longint g0, longint span, longint cs);
    int k;
    longint r;
    k = $urandom_range(0, 9);
    r = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
    if (k < 6) return 32'(g0 + r % span);
    if (k < 8) return 32'(g0 - 2 * cs + r % (span + 4 * cs));
    if (k == 8) return 32'($urandom_range(0, 1) ? g0 + span : g0);
    return $urandom;
  endfunction

  function automatic logic signed [15:0] pick_dir();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'sd0;
    if (k == 1) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic ray_word_t random_word(bit is_write);
    ray_word_t w;
    longint cs, cols, rows;
    cs = cs_reg != 0 ? cs_reg : 1;
    cols = clamp64(cols_reg, 1, MAX_COLS);
    rows = clamp64(rows_reg, 1, MAX_ROWS);
    w.mode = is_write ? MODE_WRITE : MODE_RAY;
    w.ox = pick_coord(gx0, cols * cs, cs);
    w.oy = pick_coord(gy0, rows * cs, cs);
    w.dx = pick_dir();
    w.dy = pick_dir();
    if (is_write && $urandom_range(0, 4) != 0) begin
      w.col = 8'($urandom_range(0, 32'(cols - 1)));
      w.row = 8'($urandom_range(0, 32'(rows - 1)));
    end else begin
      w.col = 8'($urandom);
      w.row = 8'($urandom);
    end
    w.occ = $urandom_range(0, 2) == 0;
    return w;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) queue_word(random_word($urandom_range(0, 9) < 3));
    wait_drained();
  endtask

  function automatic ray_word_t ray(logic signed [31:0] ox, oy, logic signed [15:0] dx, dy);
    ray_word_t w;
    w = '{MODE_RAY, ox, oy, dx, dy, 8'hA5, 8'h5A, 1'b1};
    return w;
  endfunction

  function automatic ray_word_t cell_wr(logic [7:0] c, r, bit v);
    ray_word_t w;
    w = '{MODE_WRITE, 32'h1234_5678, -32'sd1, -16'sd16384, 16'sd16384, c, r, v};
    return w;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset values of the grid
    queue_word(ray(32'sd229376, 32'sd229376, 16'sd16384, 16'sd0));
    queue_word(cell_wr(8'd10, 8'd3, 1'b1));
    queue_word(cell_wr(8'd0, 8'd0, 1'b1));
    queue_word(cell_wr(8'd255, 8'd255, 1'b1));
    queue_word(ray(32'sd32768, 32'sd229376, 16'sd16384, 16'sd0));
    queue_word(ray(32'sd32768, 32'sd32768, 16'sd0, 16'sd0));
    queue_word(ray(32'sd98304, 32'sd98304, 16'sd0, 16'sd0));
    queue_word(ray(-32'sd327680, 32'sd229376, 16'sd16384, 16'sd0));
    queue_word(ray(-32'sd327680, 32'sd229376, -16'sd16384, 16'sd0));
    queue_word(ray(32'sd16777216, 32'sd229376, -16'sd16384, 16'sd0));
    queue_word(ray(32'sd16777216, 32'sd16777216, -16'sd16384, -16'sd16384));
    queue_word(ray(32'sd65536, 32'sd65536, 16'sd16384, 16'sd16384));
    queue_word(ray(32'sd0, -32'sd196608, 16'sd16384, 16'sd0));
    queue_word(ray(32'h8000_0000, 32'h8000_0000, 16'sd16384, 16'sd16384));
    queue_word(ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, -16'sd16384, -16'sd1));
    queue_word(ray(-32'sd65536, -32'sd65536, 16'sd1, 16'sd16384));
    queue_word(cell_wr(8'd10, 8'd3, 1'b0));
    queue_word(ray(32'sd32768, 32'sd229376, 16'sd16384, 16'sd0));
    queue_word(ray(32'sd100000, 32'sd3, 16'sd7, -16'sd16384));
    wait_drained();

    set_grid(-32'sh30000, 32'sh12345, 32'd65536, 9'd16, 9'd12);
    random_phase(400);
    idle_on = 1'b0;
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 9'd1, 9'd1);
    random_phase(150);
    idle_on = 1'b1;
    set_grid(32'h7FFF_FFFF, 32'd0, 32'd1, 9'd5, 9'd300);
    random_phase(120);
    set_grid(32'hFFFF_0000, 32'h0001_0000, 32'd0, 9'd0, 9'd3);
    random_phase(100);
    set_grid(32'h0010_0000, 32'hFFF0_0000, 32'd3000, 9'd32, 9'd24);
    random_phase(760);
    set_grid(32'd0, 32'd0, 32'd65536, 9'd256, 9'd256);
    random_phase(100);

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
